[sv/jps_pkg.sv]
// Shared types and constants for the Jacobi five-point stencil sweep unit.
// No dependencies; every other file of the block but jps_ram refers to it by scoped names.
package jps_pkg;

  localparam int IDX_W    = 10;  // row_index / col_index field width
  localparam int CHANGE_W = 31;  // max_change field width
  localparam int LEN_W    = 11;  // row_length register width
  localparam int TOL_W    = 31;  // tolerance register width
  localparam int CFG_W    = 32;  // configuration write data width
  localparam int CFG_IDX_W = 4;  // configuration register index width

  localparam logic [LEN_W-1:0]    LEN_RESET  = 11'd1024;
  localparam logic [CHANGE_W-1:0] CHANGE_MAX = 31'h7FFF_FFFF;
  localparam int                  MIN_LEN    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_LENGTH = 4'd0,
    CFG_TOLERANCE  = 4'd1
  } cfg_index_e;

  // Position of one grid point as it moves down the pipeline
  typedef struct packed {
    logic [IDX_W-1:0] row_index;  // row of the updated point (row - 1 of the scan)
    logic [IDX_W-1:0] col_index;  // column of the updated point
    logic             emit;       // interior point: a result is produced
    logic             last;       // final interior point of the sweep
  } pos_t;

endpackage

[sv/jps_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the line buffers of the stencil sweep unit.
module jps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/jps_scan.sv]
// Raster scan counters: clamp the row length, give the column address and
// the position flags of each accepted grid point. Depends on jps_pkg.
module jps_scan #(
  parameter int MAX_ROW = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [jps_pkg::LEN_W-1:0]   row_length_i,
  input  logic                        advance_i,
  output logic [$clog2(MAX_ROW)-1:0]  col_o,
  output jps_pkg::pos_t               pos_o
);

  localparam int CW = $clog2(MAX_ROW);
  localparam int NW = $clog2(MAX_ROW + 1);

  logic [CW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [NW-1:0] n;
  logic [NW-1:0] r, c, c_inc, r_inc, r_m1, c_m1;

  // Effective row length, held inside [3, MAX_ROW]
  always_comb begin
    if (32'(row_length_i) < 32'(jps_pkg::MIN_LEN)) begin
      n = NW'(jps_pkg::MIN_LEN);
    end else if (32'(row_length_i) > 32'(MAX_ROW)) begin
      n = NW'(MAX_ROW);
    end else begin
      n = NW'(row_length_i);
    end
  end

  always_comb begin
    // wrap first if the length shrank under the counters
    r = NW'(row_q);
    c = NW'(col_q);
    if (c >= n) begin
      c = '0;
      r = r + NW'(1);
    end
    if (r >= n) begin
      r = '0;
    end

    c_inc = c + NW'(1);
    r_inc = r + NW'(1);
    if (c_inc >= n) begin
      col_d = '0;
      row_d = (r_inc >= n) ? '0 : CW'(r_inc);
    end else begin
      col_d = CW'(c_inc);
      row_d = CW'(r);
    end
  end

  assign r_m1 = r - NW'(1);
  assign c_m1 = c - NW'(1);

  always_comb begin
    pos_o.row_index = jps_pkg::IDX_W'(r_m1);
    pos_o.col_index = jps_pkg::IDX_W'(c_m1);
    pos_o.emit      = (r >= NW'(2)) && (c >= NW'(2));
    pos_o.last      = (r == n - NW'(1)) && (c == n - NW'(1));
  end

  assign col_o = CW'(c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (advance_i) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

[sv/jps_stencil.sv]
// Line buffers, 3x3 window and the stencil arithmetic: a read stage behind
// the line buffer RAM, then a register holding the new value. Depends on
// jps_pkg and jps_ram.
module jps_stencil #(
  parameter int MAX_ROW    = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic signed [DATA_WIDTH-1:0]  prev_value_i,
  input  logic signed [DATA_WIDTH-1:0]  rhs_value_i,
  input  logic [$clog2(MAX_ROW)-1:0]    col_i,
  input  jps_pkg::pos_t                 pos_i,
  input  logic                          out_free_i,
  output logic                          ready_o,
  output logic                          valid_o,
  output logic signed [DATA_WIDTH-1:0]  new_value_o,
  output logic signed [DATA_WIDTH-1:0]  center_o,
  output jps_pkg::pos_t                 pos_o
);

  localparam int CW = $clog2(MAX_ROW);
  localparam int DW = DATA_WIDTH;
  localparam int SW = DATA_WIDTH + 3;

  // read stage
  logic                 v1_q;
  logic signed [DW-1:0] x1_q, f1_q;
  logic [CW-1:0]        col1_q;
  jps_pkg::pos_t        pos1_q;

  // result stage
  logic                 v2_q;
  logic signed [DW-1:0] nv2_q, ctr2_q;
  jps_pkg::pos_t        pos2_q;

  logic [3*DW-1:0]      rd_word, wr_word;
  logic signed [DW-1:0] top, mid, rhs_row;
  logic signed [DW-1:0] win_q [9];
  logic signed [DW-1:0] rhs_ctr_q;
  logic                 s2_free, commit;
  logic signed [SW-1:0] sum;
  logic signed [DW:0]   quarter;
  logic signed [DW-1:0] nv;

  assign s2_free = !v2_q || !pos2_q.emit || out_free_i;
  assign ready_o = !v1_q || s2_free;
  assign commit  = v1_q && s2_free;

  // word layout: value two rows up, value one row up, source term one row up
  assign top     = rd_word[3*DW-1:2*DW];
  assign mid     = rd_word[2*DW-1:DW];
  assign rhs_row = rd_word[DW-1:0];
  assign wr_word = {mid, x1_q, f1_q};

  jps_ram #(
    .WIDTH (3 * DW),
    .DEPTH (MAX_ROW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (commit),
    .waddr_i (col1_q),
    .wdata_i (wr_word),
    .re_i    (accept_i),
    .raddr_i (col_i),
    .rdata_o (rd_word)
  );

  // up + down + left + right - rhs, exact; floor quarter is an arithmetic shift.
  // The window shifts on the same edge, so read each neighbour one place ahead.
  assign sum = SW'(win_q[2]) + SW'(win_q[8]) + SW'(win_q[4]) + SW'(mid) - SW'(rhs_ctr_q);
  assign quarter = sum[SW-1:2];

  always_comb begin
    if (quarter[DW] != quarter[DW-1]) begin
      nv = quarter[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      nv = quarter[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ready_o) begin
        v1_q <= accept_i;
      end
      if (s2_free) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      x1_q   <= prev_value_i;
      f1_q   <= rhs_value_i;
      col1_q <= col_i;
      pos1_q <= pos_i;
    end
    if (commit) begin
      win_q[0]  <= win_q[1];
      win_q[1]  <= win_q[2];
      win_q[2]  <= top;
      win_q[3]  <= win_q[4];
      win_q[4]  <= win_q[5];
      win_q[5]  <= mid;
      win_q[6]  <= win_q[7];
      win_q[7]  <= win_q[8];
      win_q[8]  <= x1_q;
      rhs_ctr_q <= rhs_row;
      nv2_q     <= nv;
      ctr2_q    <= win_q[5];
      pos2_q    <= pos1_q;
    end
  end

  assign valid_o     = v2_q;
  assign new_value_o = nv2_q;
  assign center_o    = ctr2_q;
  assign pos_o       = pos2_q;

endmodule

[sv/jps_track.sv]
// Change tracking and result register: absolute change, running maximum
// over the sweep and the convergence flag. Depends on jps_pkg.
module jps_track #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [DATA_WIDTH-1:0]      new_value_i,
  input  logic signed [DATA_WIDTH-1:0]      center_i,
  input  jps_pkg::pos_t                     pos_i,
  input  logic [jps_pkg::TOL_W-1:0]         tolerance_i,
  input  logic                              ready_i,
  output logic                              free_o,
  output logic                              valid_o,
  output logic signed [DATA_WIDTH-1:0]      new_value_o,
  output logic [jps_pkg::IDX_W-1:0]         row_index_o,
  output logic [jps_pkg::IDX_W-1:0]         col_index_o,
  output logic [jps_pkg::CHANGE_W-1:0]      max_change_o,
  output logic                              converged_o,
  output logic                              last_o
);

  localparam int DW = DATA_WIDTH;
  localparam int EW = (DW + 1 > 32) ? DW + 1 : 32;

  logic                            mv_q;
  logic signed [DW-1:0]            nv_q;
  logic [jps_pkg::IDX_W-1:0]       row_q, col_q;
  logic [jps_pkg::CHANGE_W-1:0]    max_q, largest_q, largest_d;
  logic                            conv_q, last_q;
  logic signed [DW:0]              diff;
  logic [DW:0]                     mag;
  logic [EW-1:0]                   mag_e;
  logic [jps_pkg::CHANGE_W-1:0]    change, new_max;
  logic                            load;

  assign free_o = !mv_q || ready_i;
  assign load   = valid_i && pos_i.emit && free_o;

  assign diff  = (DW+1)'(new_value_i) - (DW+1)'(center_i);
  assign mag   = diff[DW] ? -diff : diff;
  assign mag_e = EW'(mag);
  assign change = (mag_e > EW'(jps_pkg::CHANGE_MAX)) ? jps_pkg::CHANGE_MAX
                                                     : mag_e[jps_pkg::CHANGE_W-1:0];
  assign new_max = (change > largest_q) ? change : largest_q;

  // clear the running maximum after the final point of a sweep
  assign largest_d = pos_i.last ? '0 : new_max;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q      <= 1'b0;
      largest_q <= '0;
    end else begin
      if (free_o) begin
        mv_q <= valid_i && pos_i.emit;
      end
      if (load) begin
        largest_q <= largest_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      nv_q   <= new_value_i;
      row_q  <= pos_i.row_index;
      col_q  <= pos_i.col_index;
      max_q  <= new_max;
      conv_q <= pos_i.last && (new_max < tolerance_i);
      last_q <= pos_i.last;
    end
  end

  assign valid_o      = mv_q;
  assign new_value_o  = nv_q;
  assign row_index_o  = row_q;
  assign col_index_o  = col_q;
  assign max_change_o = max_q;
  assign converged_o  = conv_q;
  assign last_o       = last_q;

endmodule

[sv/jacobi_poisson_stencil_sweep_unit.sv]
// Top level of the Jacobi five-point stencil sweep unit: configuration
// registers, stream ports and the pipeline. Depends on jps_pkg, jps_scan,
// jps_stencil, jps_track (and jps_ram through jps_stencil).
//
// Usage:
//   Stream the grid in raster order on the slave channel, one beat per grid
//   point: previous iterate and scaled source term h*h*f. Boundary points are
//   taken but give no result; every interior point gives one beat on the
//   master channel with the updated value, its row and column, the largest
//   absolute change so far in the sweep and, on the beat with tlast set
//   (final interior point), the convergence flag against the tolerance.
//   Configuration (row length, tolerance) is written on the cfg channel,
//   which is always ready; write it only while no beat is in flight.
//   Pipeline: a point passes the line buffer read stage, the stencil register
//   and the result register before its result is on the master channel.
//   Throughput: one grid point per cycle while the receiver does not stall, set
//   by the single line buffer RAM that is read and written once per point.
//   Reset clears the scan counters, the pipeline valids and the running
//   maximum; the line buffers need no clearing, every entry is written one
//   row before it is read. When the receiver stalls, the result register
//   holds, and the two inner stages keep filling before tready drops.
module jacobi_poisson_stencil_sweep_unit #(
  parameter int MAX_ROW    = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave stream, fields from bit 0: prev_value, rhs_value, zero pad
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // master stream, fields from bit 0: new_value, row_index, col_index,
  // max_change, converged, zero pad
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [((DATA_WIDTH+52+7)/8)*8-1:0] m_axis_tdata,
  output logic                              m_axis_tlast,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [jps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [jps_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int CW    = $clog2(MAX_ROW);
  localparam int OUT_W = ((DATA_WIDTH + 52 + 7) / 8) * 8;

  logic [jps_pkg::LEN_W-1:0]    row_length_q;
  logic [jps_pkg::TOL_W-1:0]    tolerance_q;

  logic                         accept;
  logic [CW-1:0]                scan_col;
  jps_pkg::pos_t                scan_pos, st_pos;
  logic                         st_valid, out_free;
  logic signed [DATA_WIDTH-1:0] st_nv, st_ctr, out_nv;
  logic [jps_pkg::IDX_W-1:0]    out_row, out_col;
  logic [jps_pkg::CHANGE_W-1:0] out_max;
  logic                         out_conv;

  // Configuration: always ready, write on valid
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= jps_pkg::LEN_RESET;
      tolerance_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        jps_pkg::CFG_ROW_LENGTH: row_length_q <= cfg_data_i[jps_pkg::LEN_W-1:0];
        jps_pkg::CFG_TOLERANCE:  tolerance_q  <= cfg_data_i[jps_pkg::TOL_W-1:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  jps_scan #(
    .MAX_ROW (MAX_ROW)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .row_length_i (row_length_q),
    .advance_i    (accept),
    .col_o        (scan_col),
    .pos_o        (scan_pos)
  );

  jps_stencil #(
    .MAX_ROW    (MAX_ROW),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_stencil (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .prev_value_i (s_axis_tdata[DATA_WIDTH-1:0]),
    .rhs_value_i  (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .col_i        (scan_col),
    .pos_i        (scan_pos),
    .out_free_i   (out_free),
    .ready_o      (s_axis_tready),
    .valid_o      (st_valid),
    .new_value_o  (st_nv),
    .center_o     (st_ctr),
    .pos_o        (st_pos)
  );

  jps_track #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (st_valid),
    .new_value_i  (st_nv),
    .center_i     (st_ctr),
    .pos_i        (st_pos),
    .tolerance_i  (tolerance_q),
    .ready_i      (m_axis_tready),
    .free_o       (out_free),
    .valid_o      (m_axis_tvalid),
    .new_value_o  (out_nv),
    .row_index_o  (out_row),
    .col_index_o  (out_col),
    .max_change_o (out_max),
    .converged_o  (out_conv),
    .last_o       (m_axis_tlast)
  );

  // pack result fields from bit 0 up, zero pad to whole bytes
  assign m_axis_tdata = OUT_W'({out_conv, out_max, out_col, out_row, out_nv});

endmodule
